// File: hw/rtl/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared command codes, register indexes, constants and the word types
// passed between the front, the queue and the back of the engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // Command codes carried in the command field of an input word.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_RECOVER = 4'd1,
    OP_START   = 4'd2,
    OP_STOP    = 4'd3,
    OP_WRITE   = 4'd4,
    OP_WAITACK = 4'd5,
    OP_ACK     = 4'd6,
    OP_NAK     = 4'd7,
    OP_READ    = 4'd8
  } op_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_PULSES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT  = 1'b1;

  // Register reset values.
  localparam logic [4:0] RECOVERY_PULSES_RESET = 5'd9;
  localparam logic [7:0] ACK_POLL_LIMIT_RESET  = 8'd5;

  // Sequence lengths.
  localparam logic [4:0] MAX_PULSES      = 5'd16;
  localparam logic [4:0] WRITE_LAST_STEP = 5'd24;
  localparam logic [4:0] READ_LAST_STEP  = 5'd17;
  localparam logic [7:0] POLL_SATURATE   = 8'hFF;

  // Classified input word as held in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] write_byte;
    logic       sda_sample;
  } q_entry_t;

  // Handshake between queue and back end.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Result word.
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_failed;
  } res_t;

endpackage

// File: hw/rtl/i2cmbe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Tick input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] write_byte;
  logic       sda_sample;

  modport source(output valid, command, write_byte, sda_sample, input ready);
  modport sink(input valid, command, write_byte, sda_sample, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_failed;

  modport source(output valid, scl_level, sda_release, busy_res, done_res,
                 read_byte, ack_failed, input ready);
  modport sink(input valid, scl_level, sda_release, busy_res, done_res,
               read_byte, ack_failed, output ready);
endinterface

// File: hw/rtl/i2cmbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine front end
// Accepts tick words and classifies the command code; codes outside the
// command set are turned into no-command before entering the queue.
// ----------------------------------------------------------------------------
module i2cmbe_front import i2cmbe_pkg::*; (
  i2cmbe_in_if.sink in_ch,
  input  logic      q_full,
  output logic      q_push,
  output q_entry_t  q_data
);

  // A word is accepted whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the command code.
  always_comb begin
    q_data.write_byte = in_ch.write_byte;
    q_data.sda_sample = in_ch.sda_sample;
    if (in_ch.command >= 4'(OP_RECOVER) && in_ch.command <= 4'(OP_READ)) begin
      q_data.op = op_t'(in_ch.command);
    end else begin
      q_data.op = OP_NONE;
    end
  end

endmodule

// File: hw/rtl/i2cmbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine queue
// Two-entry word queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module i2cmbe_queue import i2cmbe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_head_t  head
);

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  // Storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/i2cmbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine back end
// Runs the pin sequencer one tick word at a time and registers the result
// word; holds the configuration registers.
// ----------------------------------------------------------------------------
module i2cmbe_back import i2cmbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  q_head_t               head,
  output logic                  pop,
  i2cmbe_out_if.source          out_ch
);

  // Configuration registers.
  logic [4:0] recovery_pulses;
  logic [7:0] ack_poll_limit;

  // Sequencer state.
  op_t        active_command, active_command_next;
  logic [4:0] tick_step, tick_step_next;
  logic [1:0] phase, phase_next;
  logic [7:0] shift_register, shift_register_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       ack_fail_flag, ack_fail_flag_next;
  logic [7:0] read_hold, read_hold_next;
  logic       done_next;

  // Output register.
  logic       out_valid;
  res_t       res, res_next;

  // Working values after a possible command launch.
  logic       launch;
  op_t        act;
  logic [4:0] step;
  logic [1:0] ph;
  logic       fin;
  logic       advance;
  logic [4:0] pulses;
  logic [7:0] limit;
  logic [7:0] poll_inc;

  // Take the next word when the output register is free or being drained.
  assign pop = head.valid && (!out_valid || out_ch.ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_pulses <= RECOVERY_PULSES_RESET;
      ack_poll_limit  <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECOVERY_PULSES: recovery_pulses <= cfg_data[4:0];
        CFG_ACK_POLL_LIMIT:  ack_poll_limit  <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Clamped register values.
  always_comb begin
    if (recovery_pulses == 5'd0) begin
      pulses = 5'd1;
    end else if (recovery_pulses > MAX_PULSES) begin
      pulses = MAX_PULSES;
    end else begin
      pulses = recovery_pulses;
    end
    limit = (ack_poll_limit == 8'd0) ? 8'd1 : ack_poll_limit;
  end

  // Next-state logic of the pin sequencer.
  always_comb begin
    launch = (active_command == OP_NONE) && (head.entry.op != OP_NONE);
    act    = launch ? head.entry.op : active_command;
    step   = launch ? 5'd0 : tick_step;
    ph     = launch ? 2'd0 : phase;

    active_command_next = act;
    tick_step_next      = step;
    phase_next          = ph;
    poll_count_next     = launch ? 8'd0 : poll_count;
    shift_register_next = (launch && head.entry.op == OP_WRITE) ?
                          head.entry.write_byte : shift_register;
    ack_fail_flag_next  = (launch && head.entry.op == OP_WAITACK) ? 1'b0 : ack_fail_flag;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    read_hold_next      = read_hold;
    poll_inc            = (poll_count_next < POLL_SATURATE) ?
                          poll_count_next + 8'd1 : poll_count_next;
    fin       = 1'b0;
    advance   = 1'b1;
    done_next = 1'b0;

    unique case (act)
      OP_RECOVER: begin
        scl_drive_next = step[0];
        if ({1'b0, step} + 6'd1 >= {pulses, 1'b0}) begin
          fin = 1'b1;
        end
      end
      OP_START: begin
        unique case (step)
          5'd0:    sda_drive_next = 1'b1;
          5'd1:    scl_drive_next = 1'b1;
          5'd2:    sda_drive_next = 1'b0;
          default: begin
            scl_drive_next = 1'b0;
            fin            = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        unique case (step)
          5'd0:    scl_drive_next = 1'b0;
          5'd1:    sda_drive_next = 1'b0;
          5'd2:    scl_drive_next = 1'b1;
          default: begin
            sda_drive_next = 1'b1;
            fin            = 1'b1;
          end
        endcase
      end
      OP_WRITE: begin
        if (step >= WRITE_LAST_STEP) begin
          scl_drive_next = 1'b0;
          fin            = 1'b1;
        end else begin
          case (ph)
            2'd0: scl_drive_next = 1'b0;
            2'd1: begin
              sda_drive_next      = shift_register_next[7];
              shift_register_next = {shift_register_next[6:0], 1'b0};
            end
            default: scl_drive_next = 1'b1;
          endcase
        end
      end
      OP_WAITACK: begin
        if (step == 5'd0) begin
          sda_drive_next = 1'b1;
        end else if (step == 5'd1) begin
          scl_drive_next = 1'b1;
        end else begin
          advance = 1'b0;
          if (!head.entry.sda_sample) begin
            scl_drive_next = 1'b0;
            fin            = 1'b1;
          end else begin
            poll_count_next = poll_inc;
            // Timeout: stop sequence picks up with SDA pulled low.
            if (poll_inc >= limit) begin
              ack_fail_flag_next  = 1'b1;
              scl_drive_next      = 1'b0;
              active_command_next = OP_STOP;
              tick_step_next      = 5'd1;
            end
          end
        end
      end
      OP_ACK, OP_NAK: begin
        if (step == 5'd0) begin
          sda_drive_next = (act == OP_NAK);
        end else if (step == 5'd1) begin
          scl_drive_next = 1'b1;
        end else begin
          scl_drive_next = 1'b0;
          fin            = 1'b1;
        end
      end
      OP_READ: begin
        if (step == 5'd0) begin
          sda_drive_next = 1'b1;
        end else if (step >= READ_LAST_STEP) begin
          shift_register_next = {shift_register_next[6:0], head.entry.sda_sample};
          scl_drive_next      = 1'b0;
          read_hold_next      = shift_register_next;
          fin                 = 1'b1;
        end else if (step[0]) begin
          if (step >= 5'd3) begin
            shift_register_next = {shift_register_next[6:0], head.entry.sda_sample};
          end
          scl_drive_next = 1'b0;
        end else begin
          scl_drive_next = 1'b1;
        end
      end
      default: begin
        active_command_next = OP_NONE;
        advance             = 1'b0;
      end
    endcase

    if (fin) begin
      active_command_next = OP_NONE;
      tick_step_next      = 5'd0;
      phase_next          = 2'd0;
      done_next           = 1'b1;
    end else if (advance && active_command_next != OP_NONE) begin
      tick_step_next = step + 5'd1;
      phase_next     = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
    end
  end

  // Result word formed from the state after this tick.
  always_comb begin
    res_next.scl_level   = scl_drive_next;
    res_next.sda_release = sda_drive_next;
    res_next.busy_res    = (active_command_next != OP_NONE);
    res_next.done_res    = done_next;
    res_next.read_byte   = read_hold_next;
    res_next.ack_failed  = ack_fail_flag_next;
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= OP_NONE;
      tick_step      <= 5'd0;
      phase          <= 2'd0;
      shift_register <= 8'd0;
      poll_count     <= 8'd0;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
      ack_fail_flag  <= 1'b0;
      read_hold      <= 8'd0;
    end else if (pop) begin
      active_command <= active_command_next;
      tick_step      <= tick_step_next;
      phase          <= phase_next;
      shift_register <= shift_register_next;
      poll_count     <= poll_count_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
      ack_fail_flag  <= ack_fail_flag_next;
      read_hold      <= read_hold_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.scl_level   = res.scl_level;
  assign out_ch.sda_release = res.sda_release;
  assign out_ch.busy_res    = res.busy_res;
  assign out_ch.done_res    = res.done_res;
  assign out_ch.read_byte   = res.read_byte;
  assign out_ch.ack_failed  = res.ack_failed;

endmodule

// File: hw/rtl/i2c_master_bit_engine_unit.sv
// Path: an accepted tick word is registered in a queue slot, then its result
// in the result register, where it waits while the result sink is not ready.
// Throughput: one tick word per cycle while the sink is ready, one step each.
// Reset: synchronous, active high; clears the queue, the sequencer to idle
// with both pins released, and the registers to 9 pulses and a poll limit of 5.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master: front end classifies tick words, a short queue
// decouples it from the back end that drives SCL and SDA one action a tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit import i2cmbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  i2cmbe_in_if.sink             in_ch,
  i2cmbe_out_if.source          out_ch
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_data;
  logic     q_pop;
  q_head_t  q_head;

  // Front end: accept and classify.
  i2cmbe_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // Decoupling queue.
  i2cmbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Back end: pin sequencer and result register.
  i2cmbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: tb/sv/tb_i2c_master_bit_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives tick words into the engine with random gaps and stalls, predicts
// the pin state, flags and read byte of every tick, and checks each result
// word in order. A directed part covers every command and the corner cases,
// then random bus transactions run under several register settings.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_unit;
  import i2cmbe_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_TICKS  = 320;
  localparam int PHASES        = 5;

  // SDA sampling styles for a command sequence.
  localparam int SDA_RANDOM = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_LOW    = 2;

  // Tracks the engine state and holds the pin states still due from the block.
  class engine_scoreboard;
    op_t        act;
    logic [5:0] step;
    logic [7:0] shreg;
    logic [7:0] polls;
    logic [7:0] rd_hold;
    logic       scl;
    logic       sda;
    logic       fail;
    logic [4:0] pulses;
    logic [7:0] poll_limit;
    res_t       pins_due[$];
    int         mismatches;

    function new();
      act        = OP_NONE;
      step       = '0;
      shreg      = '0;
      polls      = '0;
      rd_hold    = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      fail       = 1'b0;
      pulses     = RECOVERY_PULSES_RESET;
      poll_limit = ACK_POLL_LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RECOVERY_PULSES) pulses = data[4:0];
      else poll_limit = data;
    endfunction

    function bit busy();
      return act != OP_NONE;
    endfunction

    // Advances the engine by one accepted tick word and queues its pin state.
    function void take_tick(logic [3:0] cmd, logic [7:0] wbyte, logic sda_in);
      res_t r;
      bit   fin;
      bit   adv;
      int   n;
      int   lim;
      fin = 1'b0;
      adv = 1'b1;
      if (act == OP_NONE && cmd >= OP_RECOVER && cmd <= OP_READ) begin
        act   = op_t'(cmd);
        step  = '0;
        polls = '0;
        if (act == OP_WRITE) shreg = wbyte;
        if (act == OP_WAITACK) fail = 1'b0;
      end
      case (act)
        OP_RECOVER: begin
          n = pulses;
          if (n == 0) n = 1;
          if (n > MAX_PULSES) n = MAX_PULSES;
          scl = step[0];
          if (int'(step) + 1 >= 2 * n) fin = 1'b1;
        end
        OP_START: begin
          case (step)
            6'd0: sda = 1'b1;
            6'd1: scl = 1'b1;
            6'd2: sda = 1'b0;
            default: begin
              scl = 1'b0;
              fin = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          case (step)
            6'd0: scl = 1'b0;
            6'd1: sda = 1'b0;
            6'd2: scl = 1'b1;
            default: begin
              sda = 1'b1;
              fin = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          if (step >= WRITE_LAST_STEP) begin
            scl = 1'b0;
            fin = 1'b1;
          end else if (step % 3 == 0) begin
            scl = 1'b0;
          end else if (step % 3 == 1) begin
            sda   = shreg[7];
            shreg = {shreg[6:0], 1'b0};
          end else begin
            scl = 1'b1;
          end
        end
        OP_WAITACK: begin
          if (step == 6'd0) begin
            sda = 1'b1;
          end else if (step == 6'd1) begin
            scl = 1'b1;
          end else begin
            // Polling holds the step; a timeout hands over to the stop sequence.
            adv = 1'b0;
            if (!sda_in) begin
              scl = 1'b0;
              fin = 1'b1;
            end else begin
              lim = (poll_limit == 0) ? 1 : poll_limit;
              if (polls != POLL_SATURATE) polls++;
              if (polls >= lim) begin
                fail = 1'b1;
                scl  = 1'b0;
                act  = OP_STOP;
                step = 6'd1;
              end
            end
          end
        end
        OP_ACK, OP_NAK: begin
          if (step == 6'd0) begin
            sda = (act == OP_NAK);
          end else if (step == 6'd1) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
            fin = 1'b1;
          end
        end
        OP_READ: begin
          // Each bit is taken on the tick after its SCL high.
          if (step == 6'd0) begin
            sda = 1'b1;
          end else if (step >= READ_LAST_STEP) begin
            shreg   = {shreg[6:0], sda_in};
            scl     = 1'b0;
            rd_hold = shreg;
            fin     = 1'b1;
          end else if (step[0]) begin
            if (step >= 6'd3) shreg = {shreg[6:0], sda_in};
            scl = 1'b0;
          end else begin
            scl = 1'b1;
          end
        end
        default: begin
          act = OP_NONE;
          adv = 1'b0;
        end
      endcase
      if (fin) begin
        act  = OP_NONE;
        step = '0;
      end else if (adv && act != OP_NONE) begin
        step = step + 6'd1;
      end
      r.scl_level   = scl;
      r.sda_release = sda;
      r.busy_res    = (act != OP_NONE);
      r.done_res    = fin;
      r.read_byte   = rd_hold;
      r.ack_failed  = fail;
      pins_due.push_back(r);
    endfunction

    // Compares one result word with the oldest pin state still due.
    function void check_pins(res_t got);
      res_t want;
      if (pins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word scl=%b sda=%b busy=%b done=%b rd=%h fail=%b",
                   $realtime, got.scl_level, got.sda_release, got.busy_res, got.done_res,
                   got.read_byte, got.ack_failed);
        return;
      end
      want = pins_due.pop_front();
      if (got.scl_level !== want.scl_level || got.sda_release !== want.sda_release ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.read_byte !== want.read_byte || got.ack_failed !== want.ack_failed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected scl=%b sda=%b busy=%b done=%b rd=%h fail=%b",
                   $realtime, want.scl_level, want.sda_release, want.busy_res,
                   want.done_res, want.read_byte, want.ack_failed);
          $display("%0t:          actual   scl=%b sda=%b busy=%b done=%b rd=%h fail=%b",
                   $realtime, got.scl_level, got.sda_release, got.busy_res,
                   got.done_res, got.read_byte, got.ack_failed);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    cycle_count = 0;
  int                    ticks_sent = 0;
  bit                    no_idle = 1'b0;
  bit                    hold_request = 1'b0;
  engine_scoreboard      sb = new();

  i2cmbe_in_if  in_ch();
  i2cmbe_out_if out_ch();

  i2c_master_bit_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, none at all in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic pick_sda(int mode);
    if (mode == SDA_HIGH) return 1'b1;
    if (mode == SDA_LOW) return 1'b0;
    // A low sample ends an acknowledge wait, so keep it the rarer case there.
    if (sb.act == OP_WAITACK) return ($urandom_range(0, 3) != 0);
    return 1'($urandom_range(0, 1));
  endfunction

  // Ticks sent while busy mostly carry no command; the rest are ignored anyway.
  function automatic logic [3:0] pick_filler();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(1, 15));
    return OP_NONE;
  endfunction

  // Result sink with random stalls and, on request, one long hold-off.
  always begin : result_sink
    int stall;
    @(negedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      out_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      out_ch.ready <= 1'b1;
    end else begin
      stall = pick_gap();
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Register writes, accepted tick words and result words, seen at the rising edge.
  always @(posedge clk) begin : monitor
    res_t got;
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready)
        sb.take_tick(in_ch.command, in_ch.write_byte, in_ch.sda_sample);
      if (out_ch.valid && out_ch.ready) begin
        got.scl_level   = out_ch.scl_level;
        got.sda_release = out_ch.sda_release;
        got.busy_res    = out_ch.busy_res;
        got.done_res    = out_ch.done_res;
        got.read_byte   = out_ch.read_byte;
        got.ack_failed  = out_ch.ack_failed;
        sb.check_pins(got);
      end
    end
  end

  // Offers one tick word and returns at the falling edge after it is taken.
  task automatic send_tick(input logic [3:0] cmd, input logic [7:0] wbyte, input logic sda);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.write_byte <= wbyte;
    in_ch.sda_sample <= sda;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic finish_busy(input int mode);
    while (sb.busy()) send_tick(pick_filler(), 8'($urandom_range(0, 255)), pick_sda(mode));
  endtask

  task automatic run_command(input op_t op, input logic [7:0] wbyte, input int mode);
    send_tick(op, wbyte, pick_sda(mode));
    finish_busy(mode);
  endtask

  // Stops offering words and waits until every result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pins_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random episode: mostly a well-formed transfer, sometimes recovery or noise.
  task automatic random_episode();
    int pick;
    int n;
    no_idle = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      run_command(OP_START, 8'($urandom_range(0, 255)), SDA_RANDOM);
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 1)) begin
          run_command(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM);
          run_command(OP_WAITACK, 8'($urandom_range(0, 255)), SDA_RANDOM);
        end else begin
          run_command(OP_READ, 8'($urandom_range(0, 255)), SDA_RANDOM);
          run_command($urandom_range(0, 1) ? OP_ACK : OP_NAK, 8'($urandom_range(0, 255)),
                      SDA_RANDOM);
        end
      end
      // Some transfers are left open without a stop.
      if ($urandom_range(0, 4) != 0) run_command(OP_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM);
    end else if (pick < 85) begin
      run_command(OP_RECOVER, 8'($urandom_range(0, 255)), SDA_RANDOM);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_tick(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
      finish_busy(SDA_RANDOM);
    end
  endtask

  initial begin
    int code;
    int phase;
    int random_start;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = OP_NONE;
    in_ch.write_byte  = '0;
    in_ch.sda_sample  = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Idle ticks and codes beyond the command range.
    send_tick(OP_NONE, 8'h00, 1'b0);
    send_tick(OP_NONE, 8'hFF, 1'b1);
    for (code = 9; code <= 15; code++)
      send_tick(4'(code), 8'($urandom_range(0, 255)), 1'(code));

    // Every command with the reset register values.
    run_command(OP_RECOVER, 8'h00, SDA_RANDOM);
    run_command(OP_START, 8'h00, SDA_RANDOM);
    run_command(OP_WRITE, 8'hFF, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, SDA_LOW);
    run_command(OP_WRITE, 8'h00, SDA_RANDOM);
    // No acknowledge: the wait times out and a stop follows.
    run_command(OP_WAITACK, 8'h00, SDA_HIGH);
    run_command(OP_START, 8'h00, SDA_RANDOM);
    run_command(OP_WRITE, 8'hA5, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, SDA_RANDOM);
    run_command(OP_READ, 8'h00, SDA_HIGH);
    run_command(OP_ACK, 8'h00, SDA_RANDOM);
    run_command(OP_READ, 8'h00, SDA_LOW);
    run_command(OP_NAK, 8'h00, SDA_RANDOM);
    // A command offered while busy is dropped.
    send_tick(OP_STOP, 8'h00, 1'b1);
    send_tick(OP_READ, 8'h00, 1'b1);
    finish_busy(SDA_RANDOM);

    // A zero pulse count and a zero poll limit both act as one.
    settle();
    write_register(CFG_RECOVERY_PULSES, 8'd0);
    write_register(CFG_ACK_POLL_LIMIT, 8'd0);
    run_command(OP_RECOVER, 8'h00, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, SDA_HIGH);

    // Pulse counts above sixteen are capped; the longest poll limit runs out.
    settle();
    write_register(CFG_RECOVERY_PULSES, 8'd20);
    write_register(CFG_ACK_POLL_LIMIT, 8'd255);
    run_command(OP_RECOVER, 8'h00, SDA_RANDOM);
    run_command(OP_WAITACK, 8'h00, SDA_HIGH);

    // Shrinking the pulse count mid-recovery ends it on the next tick.
    settle();
    write_register(CFG_RECOVERY_PULSES, 8'd16);
    send_tick(OP_RECOVER, 8'h00, 1'b1);
    repeat (9) send_tick(OP_NONE, 8'h00, 1'b1);
    settle();
    write_register(CFG_RECOVERY_PULSES, 8'd2);
    finish_busy(SDA_RANDOM);

    // Lowering the poll limit mid-wait fails on the next high sample.
    settle();
    write_register(CFG_ACK_POLL_LIMIT, 8'd200);
    send_tick(OP_WAITACK, 8'h00, 1'b1);
    repeat (6) send_tick(OP_NONE, 8'h00, 1'b1);
    settle();
    write_register(CFG_ACK_POLL_LIMIT, 8'd3);
    finish_busy(SDA_HIGH);

    // Random transfers, one register setting per phase.
    random_start = ticks_sent;
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_register(CFG_RECOVERY_PULSES, 8'd1);
          write_register(CFG_ACK_POLL_LIMIT, 8'd1);
        end
        1: begin
          write_register(CFG_RECOVERY_PULSES, 8'd16);
          write_register(CFG_ACK_POLL_LIMIT, 8'd255);
          // The sink holds off while words keep coming, so the queue fills.
          hold_request = 1'b1;
        end
        2: begin
          write_register(CFG_RECOVERY_PULSES, 8'd0);
          write_register(CFG_ACK_POLL_LIMIT, 8'd0);
        end
        3: begin
          write_register(CFG_RECOVERY_PULSES, 8'($urandom_range(0, 255)));
          write_register(CFG_ACK_POLL_LIMIT, 8'($urandom_range(1, 8)));
        end
        default: begin
          write_register(CFG_RECOVERY_PULSES, 8'h33);
          write_register(CFG_ACK_POLL_LIMIT, 8'd5);
        end
      endcase
      while (ticks_sent - random_start < (phase + 1) * RANDOM_TICKS / PHASES)
        random_episode();
    end

    no_idle = 1'b0;
    settle();
    if (sb.mismatches == 0 && sb.pins_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: i2c_master_bit_engine_unit.f
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2cmbe_if.sv
hw/rtl/i2cmbe_front.sv
hw/rtl/i2cmbe_queue.sv
hw/rtl/i2cmbe_back.sv
hw/rtl/i2c_master_bit_engine_unit.sv
tb/sv/tb_i2c_master_bit_engine_unit.sv
